/* rtl/sfls_pkg.sv */
// ----------------------------------------------------------------------------
// sfls_pkg
// Shared types, field widths and slot schedule constants of the slotted
// frame link scheduler.
// ----------------------------------------------------------------------------
package sfls_pkg;

    // field widths
    localparam int BYTE_W      = 8;
    localparam int SLOT_W      = 7;
    localparam int FRAME_W     = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    // default sizing handed to the top level parameters
    localparam int DEF_TX_QUEUE_DEPTH = 16;
    localparam int DEF_LOG_DEPTH      = 128;
    localparam int DEF_LAST_SLOT      = 67;

    // frame counter wraps after this value (count modulo 255)
    localparam logic [FRAME_W-1:0] FRAME_LAST = 8'd254;

    // key line schedule
    localparam logic [SLOT_W-1:0] SLOT_KEY_OFF_A = 7'd1;
    localparam logic [SLOT_W-1:0] SLOT_KEY_OFF_B = 7'd30;
    localparam logic [SLOT_W-1:0] SLOT_KEY_ON_A  = 7'd24;
    localparam logic [SLOT_W-1:0] SLOT_KEY_ON_B  = 7'd53;

    // transmit windows, exclusive bounds
    localparam logic [SLOT_W-1:0] SLOT_WIN_A_LO = 7'd24;
    localparam logic [SLOT_W-1:0] SLOT_WIN_A_HI = 7'd30;
    localparam logic [SLOT_W-1:0] SLOT_WIN_B_LO = 7'd54;
    localparam logic [SLOT_W-1:0] SLOT_WIN_B_HI = 7'd60;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_BYTE = 2'd1;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_QUEUE = 2'd1,
        OP_POP   = 2'd2,
        OP_FLUSH = 2'd3
    } t_op;

    typedef struct packed {
        t_op               operation;
        logic              rx_ready;
        logic [BYTE_W-1:0] rx_byte;
        logic [BYTE_W-1:0] tx_byte;
    } t_in_item;

    typedef struct packed {
        logic               uart_send;
        logic [BYTE_W-1:0]  uart_byte;
        logic               key_line;
        logic               queue_accepted;
        logic               entry_valid;
        logic [FRAME_W-1:0] entry_frame;
        logic [SLOT_W-1:0]  entry_slot;
        logic [BYTE_W-1:0]  entry_data;
        logic               entry_is_tx;
        logic               log_dropped;
    } t_out_item;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [SLOT_W-1:0]  slot;
        logic [BYTE_W-1:0]  data;
        logic               is_tx;
    } t_log_entry;

    // slot lies in one of the two transmit windows
    function automatic logic in_tx_window(input logic [SLOT_W-1:0] slot);
        return ((slot > SLOT_WIN_A_LO) && (slot < SLOT_WIN_A_HI)) ||
               ((slot > SLOT_WIN_B_LO) && (slot < SLOT_WIN_B_HI));
    endfunction

endpackage

/* rtl/sfls_in_if.sv */
// ----------------------------------------------------------------------------
// sfls_in_if
// Valid/ready channel carrying one operation into the scheduler.
// ----------------------------------------------------------------------------
interface sfls_in_if;
    logic                valid;
    logic                ready;
    sfls_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/sfls_out_if.sv */
// ----------------------------------------------------------------------------
// sfls_out_if
// Valid/ready channel carrying one result out of the scheduler.
// ----------------------------------------------------------------------------
interface sfls_out_if;
    logic                valid;
    logic                ready;
    sfls_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/slotted_frame_link_scheduler.sv */
// ----------------------------------------------------------------------------
// slotted_frame_link_scheduler
// Time-slotted serial link sequencer: slot ticks, transmit queue, event log
// ring, key line and frame sync, with the queue and the log held in memories.
// ----------------------------------------------------------------------------
//  channel   direction  carries
//  i_in      sink       operation, rx_ready, rx_byte, tx_byte
//  o_out     source     send, key, queue and log entry result fields
//  i_cfg_*   write      enable (index 0), sync_byte (index 1)
//
//  one transaction at a time: a new one is accepted only after the last has
//  executed. the accept edge issues the queue and log reads, execution then
//  uses the registered item and writes the first log entry, and the log
//  memory's single write port takes a second entry in the cycle after that,
//  overlapping the next accept. the result is registered at execution; a
//  waiting result holds execution but not the accept of the next transaction.
//  reset clears all pointers and counters; no clearing pass over memories.
// ----------------------------------------------------------------------------
module slotted_frame_link_scheduler #(
    parameter int TX_QUEUE_DEPTH = sfls_pkg::DEF_TX_QUEUE_DEPTH,
    parameter int LOG_DEPTH      = sfls_pkg::DEF_LOG_DEPTH,
    parameter int LAST_SLOT      = sfls_pkg::DEF_LAST_SLOT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    sfls_in_if.sink                            i_in,
    sfls_out_if.source                         o_out,
    input  logic                               i_cfg_we,
    input  logic [sfls_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [sfls_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int TXQ_AW = $clog2(TX_QUEUE_DEPTH);
    localparam int TXQ_CW = $clog2(TX_QUEUE_DEPTH + 1);
    localparam int LOG_AW = $clog2(LOG_DEPTH);
    localparam logic [sfls_pkg::SLOT_W-1:0] SLOT_LAST = sfls_pkg::SLOT_W'(LAST_SLOT);

    // ring pointer step with wrap at a non power of two depth
    function automatic logic [TXQ_AW-1:0] txq_next(input logic [TXQ_AW-1:0] p);
        logic [TXQ_AW:0] q;
        q = {1'b0, p} + (TXQ_AW + 1)'(1);
        return (q >= (TXQ_AW + 1)'(TX_QUEUE_DEPTH)) ? '0 : q[TXQ_AW-1:0];
    endfunction

    function automatic logic [LOG_AW-1:0] log_next(input logic [LOG_AW-1:0] p);
        logic [LOG_AW:0] q;
        q = {1'b0, p} + (LOG_AW + 1)'(1);
        return (q >= (LOG_AW + 1)'(LOG_DEPTH)) ? '0 : q[LOG_AW-1:0];
    endfunction

    // configuration
    logic                              r_enable;
    logic [sfls_pkg::BYTE_W-1:0]       r_sync_byte;

    // schedule and pointer state
    logic [sfls_pkg::SLOT_W-1:0]       r_slot,      n_slot;
    logic [sfls_pkg::FRAME_W-1:0]      r_frame,     n_frame;
    logic                              r_key,       n_key;
    logic [TXQ_CW-1:0]                 r_tx_count,  n_tx_count;
    logic [TXQ_AW-1:0]                 r_tx_rptr,   n_tx_rptr;
    logic [TXQ_AW-1:0]                 r_tx_wptr,   n_tx_wptr;
    logic [LOG_AW-1:0]                 r_log_head,  n_log_head;
    logic [LOG_AW-1:0]                 r_log_tail,  n_log_tail;

    // pipeline control and payload
    logic                              r_ex_valid;
    sfls_pkg::t_in_item                r_item;
    logic                              r_w2_valid;
    logic [LOG_AW-1:0]                 r_w2_addr;
    sfls_pkg::t_log_entry              r_w2_data;
    logic                              r_out_valid;
    sfls_pkg::t_out_item               r_out;

    // memories and their registered read data
    logic [sfls_pkg::BYTE_W-1:0]       tx_mem  [TX_QUEUE_DEPTH];
    sfls_pkg::t_log_entry              log_mem [LOG_DEPTH];
    logic [sfls_pkg::BYTE_W-1:0]       r_tx_rd;
    sfls_pkg::t_log_entry              r_log_rd;

    // execute stage signals
    logic                              in_accept;
    logic                              ex_done;
    logic                              tx_we;
    logic                              slot_wrap;
    logic [sfls_pkg::SLOT_W-1:0]       slot_base;
    logic                              ev_rx;
    logic                              ev_b;
    sfls_pkg::t_log_entry              entry_rx;
    sfls_pkg::t_log_entry              entry_b;
    logic                              w1_valid;
    logic                              w2_valid;
    logic [LOG_AW-1:0]                 w1_addr;
    logic [LOG_AW-1:0]                 w2_addr;
    sfls_pkg::t_log_entry              w1_data;
    logic [LOG_AW-1:0]                 head1;
    logic [LOG_AW-1:0]                 tail1;
    sfls_pkg::t_out_item               res;
    logic                              log_we;
    logic [LOG_AW-1:0]                 log_waddr;
    sfls_pkg::t_log_entry              log_wdata;

    // handshakes
    assign i_in.ready  = !r_ex_valid;
    assign in_accept   = i_in.valid && !r_ex_valid;
    assign ex_done     = r_ex_valid && (!r_out_valid || o_out.ready);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // execute: next state, log writes and result
    always_comb begin
        n_slot     = r_slot;
        n_frame    = r_frame;
        n_key      = r_key;
        n_tx_count = r_tx_count;
        n_tx_rptr  = r_tx_rptr;
        n_tx_wptr  = r_tx_wptr;
        n_log_head = r_log_head;
        n_log_tail = r_log_tail;
        tx_we      = 1'b0;
        ev_rx      = 1'b0;
        ev_b       = 1'b0;
        res        = '0;
        slot_wrap  = (r_slot == SLOT_LAST);
        slot_base  = slot_wrap ? '0 : r_slot;
        entry_rx   = '{frame: r_frame, slot: r_slot, data: r_item.rx_byte, is_tx: 1'b0};
        entry_b    = '0;

        unique case (r_item.operation)
            sfls_pkg::OP_TICK: begin
                n_slot = slot_base + sfls_pkg::SLOT_W'(1);
                if (r_enable) begin
                    ev_rx = r_item.rx_ready;
                    if (slot_wrap) begin
                        n_frame       = (r_frame == sfls_pkg::FRAME_LAST) ? '0
                                        : r_frame + sfls_pkg::FRAME_W'(1);
                        res.uart_send = 1'b1;
                        res.uart_byte = r_sync_byte;
                        ev_b          = 1'b1;
                        entry_b       = '{frame: n_frame, slot: '0,
                                          data: r_sync_byte, is_tx: 1'b1};
                    end else if ((r_slot == sfls_pkg::SLOT_KEY_OFF_A) ||
                                 (r_slot == sfls_pkg::SLOT_KEY_OFF_B)) begin
                        n_key = 1'b0;
                    end else if ((r_slot == sfls_pkg::SLOT_KEY_ON_A) ||
                                 (r_slot == sfls_pkg::SLOT_KEY_ON_B)) begin
                        n_key = 1'b1;
                    end
                    // transmit window dequeue
                    if (sfls_pkg::in_tx_window(slot_base) && (r_tx_count != '0)) begin
                        n_tx_count    = r_tx_count - TXQ_CW'(1);
                        n_tx_rptr     = txq_next(r_tx_rptr);
                        res.uart_send = 1'b1;
                        res.uart_byte = r_tx_rd;
                        ev_b          = 1'b1;
                        entry_b       = '{frame: r_frame, slot: slot_base,
                                          data: r_tx_rd, is_tx: 1'b1};
                    end
                end
            end
            sfls_pkg::OP_QUEUE: begin
                if (r_tx_count < TXQ_CW'(TX_QUEUE_DEPTH)) begin
                    tx_we              = 1'b1;
                    n_tx_count         = r_tx_count + TXQ_CW'(1);
                    n_tx_wptr          = txq_next(r_tx_wptr);
                    res.queue_accepted = 1'b1;
                end
            end
            sfls_pkg::OP_POP: begin
                if (r_log_head != r_log_tail) begin
                    res.entry_valid = 1'b1;
                    res.entry_frame = r_log_rd.frame;
                    res.entry_slot  = r_log_rd.slot;
                    res.entry_data  = r_log_rd.data;
                    res.entry_is_tx = r_log_rd.is_tx;
                    n_log_tail      = log_next(r_log_tail);
                end
            end
            sfls_pkg::OP_FLUSH: begin
                n_tx_count = '0;
                n_tx_rptr  = '0;
                n_tx_wptr  = '0;
            end
        endcase

        // order the up to two log writes of a tick; full ring drops oldest
        w1_valid = ev_rx || ev_b;
        w2_valid = ev_rx && ev_b;
        w1_data  = ev_rx ? entry_rx : entry_b;
        w1_addr  = r_log_head;
        head1    = r_log_head;
        tail1    = r_log_tail;
        w2_addr  = r_log_head;
        if (w1_valid) begin
            head1 = log_next(r_log_head);
            if (head1 == r_log_tail) begin
                tail1           = log_next(r_log_tail);
                res.log_dropped = 1'b1;
            end
            n_log_head = head1;
            n_log_tail = tail1;
        end
        if (w2_valid) begin
            w2_addr    = head1;
            n_log_head = log_next(head1);
            if (n_log_head == tail1) begin
                n_log_tail      = log_next(tail1);
                res.log_dropped = 1'b1;
            end
        end

        res.key_line = n_key;
    end

    // state and control registers; configuration writes land last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_sync_byte <= '0;
            r_slot      <= '0;
            r_frame     <= '0;
            r_key       <= 1'b0;
            r_tx_count  <= '0;
            r_tx_rptr   <= '0;
            r_tx_wptr   <= '0;
            r_log_head  <= '0;
            r_log_tail  <= '0;
            r_ex_valid  <= 1'b0;
            r_w2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (ex_done) begin
                r_slot     <= n_slot;
                r_frame    <= n_frame;
                r_key      <= n_key;
                r_tx_count <= n_tx_count;
                r_tx_rptr  <= n_tx_rptr;
                r_tx_wptr  <= n_tx_wptr;
                r_log_head <= n_log_head;
                r_log_tail <= n_log_tail;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    sfls_pkg::CFG_ENABLE: begin
                        r_enable   <= i_cfg_data[0];
                        r_log_head <= '0;
                        r_log_tail <= '0;
                    end
                    sfls_pkg::CFG_SYNC_BYTE: begin
                        r_sync_byte <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (in_accept) begin
                r_ex_valid <= 1'b1;
            end else if (ex_done) begin
                r_ex_valid <= 1'b0;
            end
            r_w2_valid <= ex_done && w2_valid;
            if (ex_done) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item <= i_in.data;
        end
        if (ex_done) begin
            r_w2_addr <= w2_addr;
            r_w2_data <= entry_b;
            r_out     <= res;
        end
    end

    // transmit queue memory
    always_ff @(posedge i_clk) begin
        if (ex_done && tx_we) begin
            tx_mem[r_tx_wptr] <= r_item.tx_byte;
        end
        if (in_accept) begin
            r_tx_rd <= tx_mem[r_tx_rptr];
        end
    end

    // log ring memory, second entry of a tick written in the cycle after execute
    assign log_we    = (ex_done && w1_valid) || r_w2_valid;
    assign log_waddr = r_w2_valid ? r_w2_addr : w1_addr;
    assign log_wdata = r_w2_valid ? r_w2_data : w1_data;

    always_ff @(posedge i_clk) begin
        if (log_we) begin
            log_mem[log_waddr] <= log_wdata;
        end
        // forward the late entry when it lands on the address being read
        if (in_accept) begin
            if (r_w2_valid && (r_w2_addr == r_log_tail)) begin
                r_log_rd <= r_w2_data;
            end else begin
                r_log_rd <= log_mem[r_log_tail];
            end
        end
    end

    // checks
    a_w2_follows_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_w2_valid |-> $past(ex_done))
        else $error("late log write without a preceding execute");

    a_log_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ex_done && (r_item.operation != sfls_pkg::OP_TICK)) |-> !w1_valid)
        else $error("log write from a non-tick operation");

    a_tx_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tx_count <= TXQ_CW'(TX_QUEUE_DEPTH))
        else $error("transmit queue count beyond depth");

    a_log_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ex_done && w1_valid && !i_cfg_we) |=> (r_log_head != r_log_tail))
        else $error("log ring empty right after a write");

endmodule
